>>> rtl/sfls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfls_pkg
// Shared types and codes for the step function lower-bound lookup block.
// ---------------------------------------------------------------------------
package sfls_pkg;

    // command carried in s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic REG_QUERY_OFFSET   = 1'b0;
    localparam logic REG_ENTRIES_IN_USE = 1'b1;

    localparam int VALUE_W = 32;

    // search token handed from cell to cell (bounds travel beside it)
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] target;
    } search_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } ctrl_state_t;

endpackage

>>> rtl/step_function_lookup_strict_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// step_function_lookup_strict_top
// Breakpoint/weight table with a lower-bound search; returns the weight of
// the step below the offset-corrected query point and its interval index.
//
//  channel   direction  tdata (low bit up)                         tuser
//  s_        in         entry_index, breakpoint, weight, query      cmd
//  m_        out        step_value, interval_index, zero pad        -
//  cfg_      in         write enable, register index, write data    -
//
// A query goes from the seed register, which loads on the transfer edge,
// through the register of each search cell of the chain in turn, the
// weight table read register and the output register, which waits while
// it holds an untaken result. A table write leaves s_tready high. s_tready
// drops from a query transfer until its result is in the output register,
// which holds its data while m_tready is low.
// Reset is synchronous; the tables are not cleared.
// ---------------------------------------------------------------------------
module step_function_lookup_strict_top
    import sfls_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // entry_index, breakpoint_value, weight_value, query_point
    input  logic [0:0]    s_tuser,   // cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // step_value, interval_index, zero pad
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH+1);
    localparam int NC = CW;

    logic [7:0]                in_entry_index;
    logic [VALUE_W-1:0]        in_breakpoint;
    logic [VALUE_W-1:0]        in_weight;
    logic signed [VALUE_W-1:0] in_query;

    logic signed [VALUE_W-1:0] offset_reg;
    logic [8:0]                entries_reg;

    ctrl_state_t state_reg, state_next;

    logic                      in_xfer;
    logic                      tbl_wr;
    logic [AW-1:0]             tbl_addr;
    logic                      query_xfer;
    logic                      out_load;
    logic [VALUE_W:0]          diff;
    logic signed [VALUE_W-1:0] target;
    logic [CW-1:0]             n_sat;

    logic                      seed_valid_reg;
    logic signed [VALUE_W-1:0] seed_target_reg;
    logic [CW-1:0]             seed_hi_reg;

    search_ctl_t   link_ctl [NC+1];
    logic [CW-1:0] link_lo  [NC+1];
    logic [CW-1:0] link_hi  [NC+1];

    logic [VALUE_W-1:0] wmem [TABLE_DEPTH];
    logic [VALUE_W-1:0] wrd_reg;
    logic [CW-1:0]      final_lo_reg;

    logic               m_tvalid_reg;
    logic [VALUE_W-1:0] step_reg;
    logic [8:0]         index_reg;

    assign in_entry_index = s_tdata[7:0];
    assign in_breakpoint  = s_tdata[39:8];
    assign in_weight      = s_tdata[71:40];
    assign in_query       = s_tdata[103:72];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            entries_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_QUERY_OFFSET:   offset_reg  <= cfg_wdata;
                REG_ENTRIES_IN_USE: entries_reg <= cfg_wdata[8:0];
                default:            ;
            endcase
        end
    end

    // control
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser[0] == CMD_QUERY) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (link_ctl[NC].valid) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SEARCH: ;
            ST_HOLD:   out_load = !m_tvalid_reg || m_tready;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_xfer    = s_tvalid && s_tready;
    assign query_xfer = in_xfer && s_tuser[0] == CMD_QUERY;
    assign tbl_wr     = in_xfer && s_tuser[0] == CMD_WRITE
                        && (32'(in_entry_index) < TABLE_DEPTH);
    assign tbl_addr   = AW'(in_entry_index);

    // saturating target = query - offset
    always_comb begin
        diff = {in_query[VALUE_W-1], in_query} - {offset_reg[VALUE_W-1], offset_reg};
        if (diff[VALUE_W] != diff[VALUE_W-1]) begin
            target = diff[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                   : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            target = diff[VALUE_W-1:0];
        end
        n_sat = (32'(entries_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_valid_reg <= 1'b0;
        end else begin
            seed_valid_reg <= query_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (query_xfer) begin
            seed_target_reg <= target;
            seed_hi_reg     <= n_sat;
        end
    end

    assign link_ctl[0].valid  = seed_valid_reg;
    assign link_ctl[0].target = seed_target_reg;
    assign link_lo[0]         = '0;
    assign link_hi[0]         = seed_hi_reg;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        sfls_cell #(
            .TABLE_DEPTH (TABLE_DEPTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (tbl_wr),
            .wr_addr (tbl_addr),
            .wr_data (in_breakpoint),
            .in_ctl  (link_ctl[g]),
            .in_lo   (link_lo[g]),
            .in_hi   (link_hi[g]),
            .out_ctl (link_ctl[g+1]),
            .out_lo  (link_lo[g+1]),
            .out_hi  (link_hi[g+1])
        );
    end

    // weight table, read at the entry just below the final index
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            wmem[tbl_addr] <= in_weight;
        end
        if (link_ctl[NC].valid) begin
            wrd_reg      <= wmem[AW'(link_lo[NC] - CW'(1))];
            final_lo_reg <= link_lo[NC];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            step_reg  <= (final_lo_reg == '0) ? '0 : wrd_reg;
            index_reg <= 9'(final_lo_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, index_reg, step_reg};

endmodule

>>> rtl/sfls_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfls_cell
// One bisection step: holds a copy of the breakpoint table, probes the
// midpoint of the incoming bounds and passes narrowed bounds to the next cell.
// ---------------------------------------------------------------------------
module sfls_cell
    import sfls_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
    input  logic [VALUE_W-1:0]                    wr_data,
    input  search_ctl_t                           in_ctl,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      in_lo,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      in_hi,
    output search_ctl_t                           out_ctl,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      out_lo,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      out_hi
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH+1);

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]             mid;
    logic                      active;
    logic                      valid_reg;
    logic signed [VALUE_W-1:0] target_reg;
    logic [CW-1:0]             lo_reg;
    logic [CW-1:0]             hi_reg;
    logic [CW-1:0]             mid_reg;
    logic                      active_reg;
    logic [VALUE_W-1:0]        rdata_reg;

    always_comb begin
        active = in_lo < in_hi;
        mid    = in_lo + ((in_hi - in_lo) >> 1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[AW'(mid)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg <= in_ctl.target;
        lo_reg     <= in_lo;
        hi_reg     <= in_hi;
        mid_reg    <= mid;
        active_reg <= active;
    end

    always_comb begin
        out_ctl.valid  = valid_reg;
        out_ctl.target = target_reg;
        out_lo         = lo_reg;
        out_hi         = hi_reg;
        // a finished search just passes through
        if (active_reg) begin
            if ($signed(rdata_reg) < target_reg) begin
                out_lo = mid_reg + CW'(1);
            end else begin
                out_hi = mid_reg;
            end
        end
    end

endmodule

>>> rtl/sfls_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfls_checker
// Port-level checks for the step function lookup, bound to the top level.
// ---------------------------------------------------------------------------
module sfls_checker
    import sfls_pkg::*;
(
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [0:0]    s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [47:0]   m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // below the first breakpoint the step value is zero
    a_zero_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40:32] == 9'd0 |-> m_tdata[31:0] == 32'd0)
        else $error("non-zero step value at interval zero");

    // a table write never brings up a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_WRITE && !m_tvalid |=> !m_tvalid)
        else $error("result after a table write");

    // one query at a time
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_QUERY |=> !s_tready)
        else $error("input taken while a query is in flight");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind step_function_lookup_strict_top sfls_checker u_sfls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/step_lookup_scoreboard.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// step_lookup_scoreboard
// Watches the input, result and register ports of the step function lookup.
// It keeps its own copy of both tables and both registers and predicts the
// lower-bound index and step weight of every query transfer. Each result
// transfer is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module step_lookup_scoreboard
    import sfls_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [103:0]  s_tdata,   // entry_index, breakpoint_value, weight_value, query_point
    input  logic [0:0]    s_tuser,   // cmd
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [47:0]   m_tdata,   // step_value, interval_index, zero pad
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    output int            mismatch_count,
    output int            pending
);

    localparam int     DEPTH  = 256;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] step_value;
        logic [8:0]         interval_index;
    } step_result_t;

    logic signed [31:0] breakpoints [0:DEPTH-1];
    logic signed [31:0] weights [0:DEPTH-1];
    logic signed [31:0] offset_q;
    logic [8:0]         entries_q;
    step_result_t       expected_steps [$];

    function automatic step_result_t lower_bound_step(input logic signed [31:0] point);
        longint             diff;
        logic signed [31:0] target;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        step_result_t       res;
        diff = longint'(point) - longint'(offset_q);
        if (diff > SAT_HI) begin
            target = SAT_HI[31:0];
        end else if (diff < SAT_LO) begin
            target = SAT_LO[31:0];
        end else begin
            target = diff[31:0];
        end
        lo = 0;
        hi = (entries_q > DEPTH) ? DEPTH : entries_q;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (breakpoints[mid] < target) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        res.interval_index = lo[8:0];
        res.step_value     = (lo == 0) ? '0 : weights[lo-1];
        return res;
    endfunction

    always @(posedge aclk) begin
        step_result_t got;
        step_result_t want;
        if (!aresetn) begin
            offset_q       = '0;
            entries_q      = '0;
            mismatch_count = 0;
            expected_steps.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_QUERY_OFFSET:   offset_q  = cfg_wdata;
                    REG_ENTRIES_IN_USE: entries_q = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            // a leaving result is checked before an entering query is queued
            if (m_tvalid && m_tready) begin
                got.step_value     = m_tdata[31:0];
                got.interval_index = m_tdata[40:32];
                if (expected_steps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected step result: value %0d index %0d",
                                 got.step_value, got.interval_index);
                    end
                end else begin
                    want = expected_steps.pop_front();
                    if (got.step_value !== want.step_value ||
                        got.interval_index !== want.interval_index) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("step mismatch: expected value %0d index %0d, got value %0d index %0d",
                                     want.step_value, want.interval_index,
                                     got.step_value, got.interval_index);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_WRITE) begin
                    breakpoints[s_tdata[7:0]] = s_tdata[39:8];
                    weights[s_tdata[7:0]]     = s_tdata[71:40];
                end else begin
                    expected_steps.push_back(lower_bound_step(s_tdata[103:72]));
                end
            end
        end
        pending = expected_steps.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the step function lookup: a few directed queries on an empty
// and a four-entry table, then table loads and random mixes of queries and
// entry writes under several offset and entry-count settings, with random
// gaps on both channels except in two calm phases. The scoreboard does the predicting and comparing.
// ---------------------------------------------------------------------------
module tb;
    import sfls_pkg::*;

    localparam int                 CYCLE_LIMIT   = 400000;
    localparam int                 SETTLE_CYCLES = 16;
    localparam logic signed [31:0] Q_MIN         = 32'sh80000000;
    localparam logic signed [31:0] Q_MAX         = 32'sh7FFFFFFF;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [47:0]   m_tdata;
    logic          cfg_wr_en;
    logic [0:0]    cfg_index;
    logic [31:0]   cfg_wdata;

    int                 step_mismatches;
    int                 steps_pending;
    int                 cycle_count = 0;
    logic               calm;
    logic signed [31:0] offset_cfg;
    logic signed [31:0] bp_shadow [0:255];

    step_function_lookup_strict_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    step_lookup_scoreboard scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (step_mismatches),
        .pending        (steps_pending)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 27);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one transfer on the input channel; starts and ends at a falling edge
    task automatic send_item(input logic cmd, input logic [7:0] slot,
                             input logic [31:0] bp, input logic [31:0] w,
                             input logic [31:0] qp);
        while (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {qp, w, bp, slot};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_entry(input logic [7:0] slot, input logic [31:0] bp,
                               input logic [31:0] w);
        bp_shadow[slot] = bp;
        send_item(CMD_WRITE, slot, bp, w, $urandom);
    endtask

    task automatic query(input logic [31:0] qp);
        send_item(CMD_QUERY, 8'($urandom), $urandom, $urandom, qp);
    endtask

    // registers only change once the search pipeline has drained
    task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (steps_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (idx == REG_QUERY_OFFSET) begin
            offset_cfg = value;
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ascending breakpoints with repeats, random weights
    task automatic fill_table(input longint start, input int unsigned max_step);
        longint level;
        level = start;
        for (int i = 0; i < 256; i++) begin
            if ($urandom_range(7) != 0) begin
                level += $urandom_range(max_step);
            end
            if (level > longint'(Q_MAX)) begin
                level = longint'(Q_MAX);
            end
            write_entry(i[7:0], level[31:0], $urandom);
        end
    endtask

    task automatic random_item();
        int unsigned        pick;
        int unsigned        slot;
        longint             lo_b;
        longint             hi_b;
        longint             v;
        logic signed [31:0] qp;
        pick = $urandom_range(99);
        if (pick < 65) begin
            case ($urandom_range(5))
                0, 1, 2: begin
                    // land on, just below or just above a breakpoint
                    qp = bp_shadow[$urandom_range(255)] + offset_cfg;
                    case ($urandom_range(2))
                        0: qp = qp - 1;
                        2: qp = qp + 1;
                        default: ;
                    endcase
                end
                3: qp = $urandom;
                4: qp = $urandom_range(1) ? Q_MAX : Q_MIN;
                default: qp = $urandom_range(1) ? offset_cfg : '0;
            endcase
            query(qp);
        end else begin
            slot = $urandom_range(255);
            lo_b = (slot == 0) ? longint'(Q_MIN) : longint'(bp_shadow[slot-1]);
            hi_b = (slot == 255) ? longint'(Q_MAX) : longint'(bp_shadow[slot+1]);
            if (pick < 95 && lo_b <= hi_b) begin
                v = lo_b + longint'($urandom) % (hi_b - lo_b + 1);
                write_entry(slot[7:0], v[31:0], $urandom);
            end else begin
                // breaks the ordering now and then
                write_entry(slot[7:0], $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [31:0] phase_offset;
        logic [31:0] phase_count;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        calm       = 1'b0;
        offset_cfg = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // empty table
        query(Q_MAX);
        query(Q_MIN);
        query(32'sd0);

        // four entries spanning the whole range
        write_entry(8'd0, Q_MIN, Q_MAX);
        write_entry(8'd1, -32'sd1, Q_MIN);
        write_entry(8'd2, 32'sd0, 32'sd1);
        write_entry(8'd3, Q_MAX, -32'sd1);
        write_register(REG_ENTRIES_IN_USE, 32'd4);
        query(Q_MIN);
        query(Q_MIN + 1);
        query(-32'sd1);
        query(32'sd0);
        query(32'sd1);
        query(Q_MAX);

        // offsets that drive the subtraction into saturation
        write_register(REG_QUERY_OFFSET, Q_MAX);
        query(Q_MIN);
        query(32'sd0);
        query(Q_MAX);
        write_register(REG_QUERY_OFFSET, Q_MIN);
        query(Q_MAX);
        query(32'sd0);
        query(Q_MIN);

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                fill_table(longint'(Q_MIN) + $urandom_range(32'h3FFFFFFF), 32'h0080_0000);
            end else if (p == 4) begin
                // dense table around zero with many repeats
                fill_table(-longint'($urandom_range(2000)), 20);
            end
            case (p)
                0: begin phase_offset = '0;                           phase_count = 256; end
                1: begin phase_offset = Q_MAX;                        phase_count = 256; end
                2: begin phase_offset = Q_MIN;                        phase_count = 255; end
                3: begin phase_offset = $urandom;                     phase_count = 1;   end
                4: begin phase_offset = '0;                           phase_count = 511; end
                5: begin phase_offset = $urandom_range(2000) - 1000;  phase_count = 2;   end
                6: begin phase_offset = $urandom;                     phase_count = 257; end
                default: begin
                    phase_offset = $urandom;
                    phase_count  = $urandom_range(300);
                end
            endcase
            calm = (p == 2 || p == 3);
            write_register(REG_QUERY_OFFSET, phase_offset);
            write_register(REG_ENTRIES_IN_USE, phase_count);
            repeat (180) random_item();
        end

        s_tvalid <= 1'b0;
        while (steps_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (step_mismatches == 0 && steps_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> step_function_lookup_strict_top.f
rtl/sfls_pkg.sv
rtl/sfls_cell.sv
rtl/step_function_lookup_strict_top.sv
rtl/sfls_checker.sv
sim/step_lookup_scoreboard.sv
sim/tb.sv
